[rtl/piqt_pkg.sv]
// Package for the point-in-quadrilateral test core.
// Shared widths, counts and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package piqt_pkg;

  // Default coordinate width (signed Q16.16)
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Quadrilateral corners, each with an x and a y register
  localparam int unsigned NUM_CORNERS = 4;

  // Configuration register index width (leaves room for unused indexes)
  localparam int unsigned CFG_INDEX_WIDTH = 4;

  // Cycles from input transfer to result valid with no backpressure
  localparam int unsigned PIPE_LATENCY = 5;

  // Configuration register map
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_CORNER0_X = 4'd0,
    REG_CORNER0_Y = 4'd1,
    REG_CORNER1_X = 4'd2,
    REG_CORNER1_Y = 4'd3,
    REG_CORNER2_X = 4'd4,
    REG_CORNER2_Y = 4'd5,
    REG_CORNER3_X = 4'd6,
    REG_CORNER3_Y = 4'd7
  } reg_index_t;

endpackage

`default_nettype wire

[rtl/piqt_ifs.sv]
// Channel interfaces for the point-in-quadrilateral test core:
// point input, result output and configuration write.
// Depends on piqt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Point input channel
interface piqt_point_if import piqt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// Result output channel
interface piqt_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink   (input valid, input inside_res, output ready);
endinterface

// Configuration write channel
interface piqt_cfg_if import piqt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [CFG_INDEX_WIDTH-1:0]    index;
  logic signed [COORD_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/point_in_quad_test_core.sv]
// Point-in-quadrilateral test by crossing number, five register stages.
// Throughput: one point per cycle while the output is not stalled; each stage has its own valid bit and
// stalls only when the stage after it is full and stalled.
// Reset (rst, synchronous): clears all stage valid bits and the corners to zero.
// Depends on piqt_pkg and piqt_ifs.
`timescale 1ns / 1ps
`default_nettype none

module point_in_quad_test_core import piqt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  piqt_cfg_if.sink    cfg,
  piqt_point_if.sink  point,
  piqt_result_if.source result
);

  // Difference width, operand split for the partial products, product width
  localparam int unsigned DW   = COORD_WIDTH + 1;
  localparam int unsigned LO_W = (DW + 1) / 2;
  localparam int unsigned HI_W = DW - LO_W;
  localparam int unsigned PW   = 2 * DW;

  // ------------------------------------------------------------------
  // Corner registers
  // ------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] corner_x [NUM_CORNERS];
  logic signed [COORD_WIDTH-1:0] corner_y [NUM_CORNERS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        corner_x[k] <= '0;
        corner_y[k] <= '0;
      end
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CORNER0_X: corner_x[0] <= cfg.data;
        REG_CORNER0_Y: corner_y[0] <= cfg.data;
        REG_CORNER1_X: corner_x[1] <= cfg.data;
        REG_CORNER1_Y: corner_y[1] <= cfg.data;
        REG_CORNER2_X: corner_x[2] <= cfg.data;
        REG_CORNER2_Y: corner_y[2] <= cfg.data;
        REG_CORNER3_X: corner_x[3] <= cfg.data;
        REG_CORNER3_Y: corner_y[3] <= cfg.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its item moves on
  // ------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

  assign s5_ready    = !s5_valid || result.ready;
  assign s4_ready    = !s4_valid || s5_ready;
  assign s3_ready    = !s3_valid || s4_ready;
  assign s2_ready    = !s2_valid || s3_ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign point.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= point.valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
      if (s5_ready) s5_valid <= s4_valid;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: edge and point differences, straddle test
  // ------------------------------------------------------------------
  logic signed [DW-1:0]    s1_dx [NUM_CORNERS];
  logic signed [DW-1:0]    s1_dy [NUM_CORNERS];
  logic signed [DW-1:0]    s1_rx [NUM_CORNERS];
  logic signed [DW-1:0]    s1_ry [NUM_CORNERS];
  logic [NUM_CORNERS-1:0]  s1_straddle;

  logic signed [DW-1:0]    dx_next [NUM_CORNERS];
  logic signed [DW-1:0]    dy_next [NUM_CORNERS];
  logic signed [DW-1:0]    rx_next [NUM_CORNERS];
  logic signed [DW-1:0]    ry_next [NUM_CORNERS];
  logic [NUM_CORNERS-1:0]  straddle_next;

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      // edge i runs from corner i to the next corner, closing at corner 0
      dx_next[i] = {corner_x[(i + 1) % NUM_CORNERS][COORD_WIDTH-1],
                    corner_x[(i + 1) % NUM_CORNERS]}
                 - {corner_x[i][COORD_WIDTH-1], corner_x[i]};
      dy_next[i] = {corner_y[(i + 1) % NUM_CORNERS][COORD_WIDTH-1],
                    corner_y[(i + 1) % NUM_CORNERS]}
                 - {corner_y[i][COORD_WIDTH-1], corner_y[i]};
      rx_next[i] = {point.point_x[COORD_WIDTH-1], point.point_x}
                 - {corner_x[i][COORD_WIDTH-1], corner_x[i]};
      ry_next[i] = {point.point_y[COORD_WIDTH-1], point.point_y}
                 - {corner_y[i][COORD_WIDTH-1], corner_y[i]};
      // lower end inclusive, upper end exclusive
      straddle_next[i] =
        (corner_y[i] <= point.point_y &&
         corner_y[(i + 1) % NUM_CORNERS] > point.point_y) ||
        (corner_y[i] > point.point_y &&
         corner_y[(i + 1) % NUM_CORNERS] <= point.point_y);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        s1_dx[i] <= dx_next[i];
        s1_dy[i] <= dy_next[i];
        s1_rx[i] <= rx_next[i];
        s1_ry[i] <= ry_next[i];
      end
      s1_straddle <= straddle_next;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: sign/magnitude form of both products
  // left = rx * |dy|, right = ry * sign(dy) * dx
  // ------------------------------------------------------------------
  function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? (~v + 1'b1) : v;
    return m;
  endfunction

  logic [DW-1:0]          s2_mrx [NUM_CORNERS];
  logic [DW-1:0]          s2_mdy [NUM_CORNERS];
  logic [DW-1:0]          s2_mry [NUM_CORNERS];
  logic [DW-1:0]          s2_mdx [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] s2_neg_l;
  logic [NUM_CORNERS-1:0] s2_neg_r;
  logic [NUM_CORNERS-1:0] s2_straddle;

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        s2_mrx[i]   <= mag_of(s1_rx[i]);
        s2_mdy[i]   <= mag_of(s1_dy[i]);
        s2_mry[i]   <= mag_of(s1_ry[i]);
        s2_mdx[i]   <= mag_of(s1_dx[i]);
        // negative only when the product is nonzero
        s2_neg_l[i] <= s1_rx[i][DW-1] && (s1_dy[i] != '0);
        s2_neg_r[i] <= (s1_ry[i][DW-1] ^ s1_dy[i][DW-1] ^ s1_dx[i][DW-1]) &&
                       (s1_ry[i] != '0) && (s1_dx[i] != '0);
      end
      s2_straddle <= s1_straddle;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: partial products on split magnitudes
  // ------------------------------------------------------------------
  logic [2*LO_W-1:0]      s3_ll_l [NUM_CORNERS];
  logic [DW-1:0]          s3_lh_l [NUM_CORNERS];
  logic [DW-1:0]          s3_hl_l [NUM_CORNERS];
  logic [2*HI_W-1:0]      s3_hh_l [NUM_CORNERS];
  logic [2*LO_W-1:0]      s3_ll_r [NUM_CORNERS];
  logic [DW-1:0]          s3_lh_r [NUM_CORNERS];
  logic [DW-1:0]          s3_hl_r [NUM_CORNERS];
  logic [2*HI_W-1:0]      s3_hh_r [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] s3_neg_l;
  logic [NUM_CORNERS-1:0] s3_neg_r;
  logic [NUM_CORNERS-1:0] s3_straddle;

  logic [2*LO_W-1:0]      ll_l_next [NUM_CORNERS];
  logic [DW-1:0]          lh_l_next [NUM_CORNERS];
  logic [DW-1:0]          hl_l_next [NUM_CORNERS];
  logic [2*HI_W-1:0]      hh_l_next [NUM_CORNERS];
  logic [2*LO_W-1:0]      ll_r_next [NUM_CORNERS];
  logic [DW-1:0]          lh_r_next [NUM_CORNERS];
  logic [DW-1:0]          hl_r_next [NUM_CORNERS];
  logic [2*HI_W-1:0]      hh_r_next [NUM_CORNERS];

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      ll_l_next[i] = s2_mrx[i][LO_W-1:0]  * s2_mdy[i][LO_W-1:0];
      lh_l_next[i] = s2_mrx[i][LO_W-1:0]  * s2_mdy[i][DW-1:LO_W];
      hl_l_next[i] = s2_mrx[i][DW-1:LO_W] * s2_mdy[i][LO_W-1:0];
      hh_l_next[i] = s2_mrx[i][DW-1:LO_W] * s2_mdy[i][DW-1:LO_W];
      ll_r_next[i] = s2_mry[i][LO_W-1:0]  * s2_mdx[i][LO_W-1:0];
      lh_r_next[i] = s2_mry[i][LO_W-1:0]  * s2_mdx[i][DW-1:LO_W];
      hl_r_next[i] = s2_mry[i][DW-1:LO_W] * s2_mdx[i][LO_W-1:0];
      hh_r_next[i] = s2_mry[i][DW-1:LO_W] * s2_mdx[i][DW-1:LO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        s3_ll_l[i] <= ll_l_next[i];
        s3_lh_l[i] <= lh_l_next[i];
        s3_hl_l[i] <= hl_l_next[i];
        s3_hh_l[i] <= hh_l_next[i];
        s3_ll_r[i] <= ll_r_next[i];
        s3_lh_r[i] <= lh_r_next[i];
        s3_hl_r[i] <= hl_r_next[i];
        s3_hh_r[i] <= hh_r_next[i];
      end
      s3_neg_l    <= s2_neg_l;
      s3_neg_r    <= s2_neg_r;
      s3_straddle <= s2_straddle;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: sum partial products into full magnitudes
  // ------------------------------------------------------------------
  logic [PW-1:0]          s4_pl [NUM_CORNERS];
  logic [PW-1:0]          s4_pr [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] s4_neg_l;
  logic [NUM_CORNERS-1:0] s4_neg_r;
  logic [NUM_CORNERS-1:0] s4_straddle;

  logic [PW-1:0]          pl_next [NUM_CORNERS];
  logic [PW-1:0]          pr_next [NUM_CORNERS];

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      pl_next[i] = (PW'(s3_hh_l[i]) << (2 * LO_W))
                 + ((PW'(s3_lh_l[i]) + PW'(s3_hl_l[i])) << LO_W)
                 + PW'(s3_ll_l[i]);
      pr_next[i] = (PW'(s3_hh_r[i]) << (2 * LO_W))
                 + ((PW'(s3_lh_r[i]) + PW'(s3_hl_r[i])) << LO_W)
                 + PW'(s3_ll_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        s4_pl[i] <= pl_next[i];
        s4_pr[i] <= pr_next[i];
      end
      s4_neg_l    <= s3_neg_l;
      s4_neg_r    <= s3_neg_r;
      s4_straddle <= s3_straddle;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: signed compare per edge, crossing parity, output register
  // ------------------------------------------------------------------
  logic                   inside_res;
  logic [NUM_CORNERS-1:0] left_of;
  logic                   inside_next;

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      if (s4_neg_l[i] != s4_neg_r[i]) begin
        left_of[i] = s4_neg_l[i];
      end else if (!s4_neg_l[i]) begin
        left_of[i] = s4_pl[i] < s4_pr[i];
      end else begin
        left_of[i] = s4_pr[i] < s4_pl[i];
      end
    end
    inside_next = ^(left_of & s4_straddle);
  end

  always_ff @(posedge clk) begin
    if (s5_ready) begin
      inside_res <= inside_next;
    end
  end

  assign result.valid      = s5_valid;
  assign result.inside_res = inside_res;

endmodule

`default_nettype wire

[rtl/piqt_checker.sv]
// Port-level checker for point_in_quad_test_core, attached by bind.
// Depends on piqt_pkg and on the core's interface ports.
`timescale 1ns / 1ps
`default_nettype none

module piqt_checker import piqt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic point_valid,
  input logic point_ready,
  input logic result_valid,
  input logic result_ready,
  input logic result_inside_res
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A point transfer shows up as a valid result once the pipeline latency has passed
  a_latency: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_ready |-> ##PIPE_LATENCY result_valid)
    else $error("result missing after pipeline latency");

  // Input side only stalls when every stage is full and the output is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !point_ready |-> result_valid && !result_ready)
    else $error("input stalled while pipeline could advance");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_inside_res))
    else $error("stalled result changed");

endmodule

bind point_in_quad_test_core piqt_checker u_piqt_checker (
  .clk               (clk),
  .rst               (rst),
  .point_valid       (point.valid),
  .point_ready       (point.ready),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .result_inside_res (result.inside_res)
);

`default_nettype wire
